/* sv/ttrb_pkg.sv */
package ttrb_pkg;

  localparam int CHANNELS      = 4;
  localparam int DEPTH         = 1024;
  localparam int SAMPLE_FIELDS = 4;
  localparam int WORD_W        = 32;
  localparam int ROW_W         = $clog2(DEPTH);
  localparam int LEN_W         = ROW_W + 1;
  localparam int ROW_DATA_W    = CHANNELS * WORD_W;
  localparam int CNT_W         = 17;
  localparam int POST_W        = 16;
  localparam int RLEN_W        = 11;
  localparam int FIELD_ROW_W   = 10;
  localparam int PHASE_W       = 2;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int RLEN_RESET    = 1024;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
  localparam logic [PHASE_W-1:0] PH_TRACING   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_STOP_SEEN = 2'd2;
  localparam logic [PHASE_W-1:0] PH_FINISHED  = 2'd3;

  localparam logic REG_POST_STOP = 1'b0;
  localparam logic REG_RING_LEN  = 1'b1;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic [FIELD_ROW_W-1:0] rows;
    logic                   row_valid;
  } meta_t;

endpackage

/* sv/ttrb_if.sv */
interface ttrb_in_if import ttrb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic                   start_trigger;
  logic                   stop_trigger;
  logic [WORD_W-1:0]      sample_0;
  logic [WORD_W-1:0]      sample_1;
  logic [WORD_W-1:0]      sample_2;
  logic [WORD_W-1:0]      sample_3;
  logic [FIELD_ROW_W-1:0] read_row;

  modport source (
    output valid, mode, start_trigger, stop_trigger,
    output sample_0, sample_1, sample_2, sample_3, read_row,
    input  ready
  );
  modport sink (
    input  valid, mode, start_trigger, stop_trigger,
    input  sample_0, sample_1, sample_2, sample_3, read_row,
    output ready
  );
endinterface

interface ttrb_out_if import ttrb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PHASE_W-1:0]     trace_phase_out;
  logic [FIELD_ROW_W-1:0] stored_rows;
  logic                   row_valid;
  logic [WORD_W-1:0]      data_0;
  logic [WORD_W-1:0]      data_1;
  logic [WORD_W-1:0]      data_2;
  logic [WORD_W-1:0]      data_3;

  modport source (
    output valid, trace_phase_out, stored_rows, row_valid,
    output data_0, data_1, data_2, data_3,
    input  ready
  );
  modport sink (
    input  valid, trace_phase_out, stored_rows, row_valid,
    input  data_0, data_1, data_2, data_3,
    output ready
  );
endinterface

/* sv/ttrb_ram.sv */
module ttrb_ram #(
  parameter int WIDTH = 32,
  parameter int ROWS  = 1024,
  parameter int AW    = $clog2(ROWS)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [ROWS];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/ttrb_ctrl.sv */
module ttrb_ctrl import ttrb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_go_i,
  input  logic                   read_go_i,
  input  logic                   start_trigger_i,
  input  logic                   stop_trigger_i,
  input  word_t                  sample_i [SAMPLE_FIELDS],
  input  logic [FIELD_ROW_W-1:0] read_row_i,
  input  logic [POST_W-1:0]      post_stop_samples_i,
  input  logic [RLEN_W-1:0]      ring_length_i,
  input  logic                   ring_clear_i,
  output logic                   wr_en_o,
  output logic [ROW_W-1:0]       wr_addr_o,
  output logic [ROW_DATA_W-1:0]  wr_data_o,
  output logic [ROW_W-1:0]       rd_addr_o,
  output meta_t                  meta_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, old_cnt;
  logic [ROW_W-1:0]   write_q, write_d;
  logic [ROW_W-1:0]   oldest_q, oldest_d;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   held_now, held_next;
  logic [LEN_W-1:0]   rd_sum;

  function automatic logic [ROW_W-1:0] ring_next(input logic [ROW_W-1:0] p,
                                                 input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] n;
    n = LEN_W'(p) + LEN_W'(1);
    return (n >= l) ? '0 : n[ROW_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] rows_held(input logic [ROW_W-1:0] w,
                                                 input logic [ROW_W-1:0] o,
                                                 input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    if (w >= o) begin
      r = LEN_W'(w) - LEN_W'(o);
    end else begin
      r = LEN_W'(w) + l - LEN_W'(o);
    end
    return r;
  endfunction

  always_comb begin
    if (32'(ring_length_i) > DEPTH) begin
      len = LEN_W'(DEPTH);
    end else if (ring_length_i < RLEN_W'(2)) begin
      len = LEN_W'(2);
    end else begin
      len = LEN_W'(ring_length_i);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    old_cnt  = cnt_q;
    write_d  = write_q;
    oldest_d = oldest_q;
    wr_en_o  = 1'b0;
    if (ring_clear_i) begin
      write_d  = '0;
      oldest_d = '0;
    end else if (tick_go_i) begin
      if (phase_d == PH_IDLE && start_trigger_i) begin
        phase_d = PH_TRACING;
      end
      if (phase_d == PH_TRACING && stop_trigger_i) begin
        phase_d = PH_STOP_SEEN;
        cnt_d   = '0;
      end
      if (phase_d == PH_STOP_SEEN) begin
        old_cnt = cnt_d;
        if (cnt_d != '1) begin
          cnt_d = cnt_d + CNT_W'(1);
        end
        if (old_cnt >= CNT_W'(post_stop_samples_i)) begin
          phase_d = PH_FINISHED;
        end
      end
      if (phase_d == PH_TRACING || phase_d == PH_STOP_SEEN) begin
        wr_en_o = 1'b1;
        write_d = ring_next(write_q, len);
        if (write_d == oldest_q) begin
          oldest_d = ring_next(oldest_q, len);
        end
      end
    end
  end

  always_comb begin
    wr_data_o = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < SAMPLE_FIELDS) begin
        wr_data_o[c*WORD_W +: WORD_W] = sample_i[c % SAMPLE_FIELDS];
      end
    end
  end

  assign wr_addr_o = write_q;

  assign held_now  = rows_held(write_q, oldest_q, len);
  assign held_next = rows_held(write_d, oldest_d, len);

  assign rd_sum    = LEN_W'(oldest_q) + LEN_W'(read_row_i);
  assign rd_addr_o = (rd_sum >= len) ? ROW_W'(rd_sum - len) : rd_sum[ROW_W-1:0];

  assign meta_o.phase     = phase_d;
  assign meta_o.rows      = FIELD_ROW_W'(held_next);
  assign meta_o.row_valid = read_go_i && (32'(read_row_i) < 32'(held_now));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      write_q  <= '0;
      oldest_q <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      write_q  <= write_d;
      oldest_q <= oldest_d;
    end
  end

endmodule

/* sv/ttrb_out.sv */
module ttrb_out import ttrb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_go_i,
  input  meta_t                 meta_i,
  input  logic [ROW_DATA_W-1:0] row_i,
  output logic                  ready_o,
  ttrb_out_if.source            res
);

  logic  a_valid_q, a_valid_d;
  logic  b_valid_q, b_valid_d;
  meta_t a_meta_q;
  meta_t b_meta_q;
  word_t b_data_q [SAMPLE_FIELDS];
  logic  b_load;

  assign b_load  = a_valid_q && (!b_valid_q || res.ready);
  assign ready_o = !a_valid_q || b_load;

  always_comb begin
    a_valid_d = a_valid_q;
    if (item_go_i) begin
      a_valid_d = 1'b1;
    end else if (b_load) begin
      a_valid_d = 1'b0;
    end
    b_valid_d = b_valid_q;
    if (b_load) begin
      b_valid_d = 1'b1;
    end else if (res.ready) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_go_i) begin
      a_meta_q <= meta_i;
    end
    if (b_load) begin
      b_meta_q <= a_meta_q;
      for (int c = 0; c < SAMPLE_FIELDS; c++) begin
        if (c < CHANNELS && a_meta_q.row_valid) begin
          b_data_q[c] <= row_i[(c % CHANNELS)*WORD_W +: WORD_W];
        end else begin
          b_data_q[c] <= '0;
        end
      end
    end
  end

  assign res.valid           = b_valid_q;
  assign res.trace_phase_out = b_meta_q.phase;
  assign res.stored_rows     = b_meta_q.rows;
  assign res.row_valid       = b_meta_q.row_valid;
  assign res.data_0          = b_data_q[0];
  assign res.data_1          = b_data_q[1];
  assign res.data_2          = b_data_q[2];
  assign res.data_3          = b_data_q[3];

endmodule

/* sv/triggered_trace_ring_buffer.sv */
// Channel  Direction  Handshake          Word
// req_i    in         valid/ready        mode, triggers, four samples, read row
// res_o    out        valid/ready        phase, stored rows, row valid, four data
// APB      in         psel/penable       post_stop_samples at 0, ring_length at 4
//
// One word is taken every cycle unless res_o stalls; results pass through stages A and B.
// The row store is a single memory with one write and one registered read port.
// Reset clears the phase, counter and ring pointers; the row store is not cleared.
// Two output stages let one further word enter while a result waits to be taken.
module triggered_trace_ring_buffer import ttrb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ttrb_in_if.sink            req_i,
  ttrb_out_if.source         res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [POST_W-1:0]     post_stop_q;
  logic [RLEN_W-1:0]     ring_len_q;
  logic                  cfg_we;
  logic                  ring_clear;
  logic                  item_go;
  logic                  tick_go;
  logic                  read_go;
  logic                  in_ready;
  word_t                 samples [SAMPLE_FIELDS];
  logic                  wr_en;
  logic [ROW_W-1:0]      wr_addr;
  logic [ROW_DATA_W-1:0] wr_data;
  logic [ROW_W-1:0]      rd_addr;
  logic [ROW_DATA_W-1:0] rd_data;
  meta_t                 meta;

  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;
  assign ring_clear = cfg_we && (paddr[2] == REG_RING_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_stop_q <= '0;
      ring_len_q  <= RLEN_W'(RLEN_RESET);
    end else if (cfg_we) begin
      case (paddr[2])
        REG_POST_STOP: post_stop_q <= pwdata[POST_W-1:0];
        REG_RING_LEN:  ring_len_q  <= pwdata[RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POST_STOP: prdata = PDATA_W'(post_stop_q);
      REG_RING_LEN:  prdata = PDATA_W'(ring_len_q);
      default:       prdata = '0;
    endcase
  end

  assign req_i.ready = in_ready;
  assign item_go     = req_i.valid && in_ready;
  assign tick_go     = item_go && (req_i.mode == MODE_TICK);
  assign read_go     = item_go && (req_i.mode == MODE_READ);

  assign samples[0] = req_i.sample_0;
  assign samples[1] = req_i.sample_1;
  assign samples[2] = req_i.sample_2;
  assign samples[3] = req_i.sample_3;

  ttrb_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .tick_go_i           (tick_go),
    .read_go_i           (read_go),
    .start_trigger_i     (req_i.start_trigger),
    .stop_trigger_i      (req_i.stop_trigger),
    .sample_i            (samples),
    .read_row_i          (req_i.read_row),
    .post_stop_samples_i (post_stop_q),
    .ring_length_i       (ring_len_q),
    .ring_clear_i        (ring_clear),
    .wr_en_o             (wr_en),
    .wr_addr_o           (wr_addr),
    .wr_data_o           (wr_data),
    .rd_addr_o           (rd_addr),
    .meta_o              (meta)
  );

  ttrb_ram #(
    .WIDTH (ROW_DATA_W),
    .ROWS  (DEPTH),
    .AW    (ROW_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (item_go),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ttrb_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_go_i (item_go),
    .meta_i    (meta),
    .row_i     (rd_data),
    .ready_o   (in_ready),
    .res       (res_o)
  );

endmodule

/* verif/ttrb_checker.sv */
module ttrb_checker import ttrb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ttrb_in_if                 req,
  ttrb_out_if                res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending,
  output int                 valid_reads,
  output int                 peak_rows
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PHASE_W-1:0]                   phase;
    logic [FIELD_ROW_W-1:0]               rows;
    logic                                 row_valid;
    logic [SAMPLE_FIELDS-1:0][WORD_W-1:0] data;
  } trace_result_t;

  trace_result_t       awaited_results[$];
  word_t               row_store [DEPTH][CHANNELS];
  logic [ROW_W-1:0]    head_row;
  logic [ROW_W-1:0]    tail_row;
  logic [PHASE_W-1:0]  phase;
  logic [CNT_W-1:0]    post_count;
  logic [POST_W-1:0]   post_limit;
  logic [RLEN_W-1:0]   ring_len;
  int                  result_no;

  function automatic int ring_used();
    int len;
    len = int'(ring_len);
    if (len < 2) len = 2;
    if (len > DEPTH) len = DEPTH;
    return len;
  endfunction

  function automatic logic [ROW_W-1:0] ring_step(logic [ROW_W-1:0] p, int len);
    int n;
    n = int'(p) + 1;
    return (n >= len) ? '0 : ROW_W'(n);
  endfunction

  function automatic int rows_held(int len);
    return (int'(head_row) + len - int'(tail_row)) % len;
  endfunction

  task automatic report(input string field, input logic [WORD_W-1:0] got,
                        input logic [WORD_W-1:0] want);
    fail_count++;
    if (fail_count <= 100)
      $display("word %0d: %s is %0h, expected %0h", result_no, field, got, want);
  endtask

  task automatic predict_word();
    trace_result_t want;
    word_t         samples [SAMPLE_FIELDS];
    int            len;
    int            held;
    int            r;
    logic          done;
    want = '0;
    len = ring_used();
    samples[0] = req.sample_0;
    samples[1] = req.sample_1;
    samples[2] = req.sample_2;
    samples[3] = req.sample_3;
    if (req.mode == MODE_TICK) begin
      if (phase == PH_IDLE && req.start_trigger) phase = PH_TRACING;
      if (phase == PH_TRACING && req.stop_trigger) begin
        phase = PH_STOP_SEEN;
        post_count = '0;
      end
      if (phase == PH_STOP_SEEN) begin
        done = (post_count >= CNT_W'(post_limit));
        if (post_count != '1) post_count = post_count + 1'b1;
        if (done) phase = PH_FINISHED;
      end
      if (phase == PH_TRACING || phase == PH_STOP_SEEN) begin
        for (int c = 0; c < CHANNELS; c++)
          row_store[head_row][c] = (c < SAMPLE_FIELDS) ? samples[c] : '0;
        head_row = ring_step(head_row, len);
        if (head_row == tail_row) tail_row = ring_step(tail_row, len);
      end
    end else begin
      r = int'(req.read_row);
      if (r < rows_held(len)) begin
        want.row_valid = 1'b1;
        valid_reads++;
        for (int c = 0; c < SAMPLE_FIELDS && c < CHANNELS; c++)
          want.data[c] = row_store[(int'(tail_row) + r) % len][c];
      end
    end
    held = rows_held(len);
    if (held > peak_rows) peak_rows = held;
    want.phase = phase;
    want.rows  = FIELD_ROW_W'(held);
    awaited_results.push_back(want);
  endtask

  task automatic check_word();
    trace_result_t want;
    if (awaited_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 100) $display("word %0d arrived with nothing expected", result_no);
    end else begin
      want = awaited_results.pop_front();
      if (res.trace_phase_out !== want.phase)
        report("trace_phase_out", WORD_W'(res.trace_phase_out), WORD_W'(want.phase));
      if (res.stored_rows !== want.rows)
        report("stored_rows", WORD_W'(res.stored_rows), WORD_W'(want.rows));
      if (res.row_valid !== want.row_valid)
        report("row_valid", WORD_W'(res.row_valid), WORD_W'(want.row_valid));
      if (res.data_0 !== want.data[0]) report("data_0", res.data_0, want.data[0]);
      if (res.data_1 !== want.data[1]) report("data_1", res.data_1, want.data[1]);
      if (res.data_2 !== want.data[2]) report("data_2", res.data_2, want.data[2]);
      if (res.data_3 !== want.data[3]) report("data_3", res.data_3, want.data[3]);
    end
    result_no++;
  endtask

  initial begin
    fail_count  = 0;
    pending     = 0;
    valid_reads = 0;
    peak_rows   = 0;
    result_no   = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      head_row   = '0;
      tail_row   = '0;
      phase      = PH_IDLE;
      post_count = '0;
      post_limit = '0;
      ring_len   = RLEN_W'(RLEN_RESET);
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_POST_STOP) begin
          post_limit = pwdata[POST_W-1:0];
        end else if (paddr[PADDR_W-1:2] == REG_RING_LEN) begin
          ring_len = pwdata[RLEN_W-1:0];
          head_row = '0;
          tail_row = '0;
        end
      end
      if (req.valid && req.ready) predict_word();
      if (res.valid && res.ready) check_word();
    end
    pending = awaited_results.size();
  end

endmodule

/* verif/triggered_trace_ring_buffer_tb.sv */
module triggered_trace_ring_buffer_tb import ttrb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;
  int valid_reads;
  int peak_rows;

  int   tick_count;
  int   read_count;
  int   write_count;
  int   burst_left;
  logic gappy;
  int   stall_style;
  int   stall_left;
  logic [7:0] stall_mask;
  int   stall_beat;
  int   ring_span;
  int   quiet;

  ttrb_in_if  req ();
  ttrb_out_if res ();

  triggered_trace_ring_buffer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ttrb_checker trace_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .res         (res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .valid_reads (valid_reads),
    .peak_rows   (peak_rows)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    case (stall_style)
      0: res.ready = 1'b1;
      1: res.ready = 1'($urandom_range(0, 1));
      2: begin
        if (stall_left > 0) begin
          stall_left--;
          res.ready = 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(4, 30);
          res.ready = 1'b0;
        end else begin
          res.ready = 1'b1;
        end
      end
      default: begin
        res.ready = stall_mask[stall_beat];
        stall_beat = (stall_beat + 1) % 8;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) || (psel && penable && pready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(input logic m, input logic st, input logic sp,
                           input word_t s0, input word_t s1, input word_t s2,
                           input word_t s3, input logic [FIELD_ROW_W-1:0] row);
    int gap;
    if (gappy) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 8);
        req.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left--;
    end
    req.valid         = 1'b1;
    req.mode          = m;
    req.start_trigger = st;
    req.stop_trigger  = sp;
    req.sample_0      = s0;
    req.sample_1      = s1;
    req.sample_2      = s2;
    req.sample_3      = s3;
    req.read_row      = row;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (m == MODE_TICK) tick_count++;
    else read_count++;
  endtask

  task automatic tick(input logic st, input logic sp);
    send_word(MODE_TICK, st, sp, $urandom, $urandom, $urandom, $urandom,
              FIELD_ROW_W'($urandom));
  endtask

  task automatic read_at(input logic [FIELD_ROW_W-1:0] row, input logic st, input logic sp);
    send_word(MODE_READ, st, sp, $urandom, $urandom, $urandom, $urandom, row);
  endtask

  task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] value);
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    write_count++;
    if (idx == REG_RING_LEN) begin
      ring_span = int'(value[RLEN_W-1:0]);
      if (ring_span < 2) ring_span = 2;
      if (ring_span > DEPTH) ring_span = DEPTH;
    end
  endtask

  task automatic run_phase(input int count, input int read_pct, input int style,
                           input logic triggers_free);
    int top_row;
    stall_style = style;
    stall_mask  = 8'($urandom_range(1, 255));
    gappy       = 1'($urandom_range(0, 2) != 0);
    top_row     = (ring_span > 1023) ? 1023 : ring_span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        if ($urandom_range(0, 9) == 0)
          read_at(FIELD_ROW_W'($urandom_range(0, 1023)), 1'($urandom), 1'($urandom));
        else
          read_at(FIELD_ROW_W'($urandom_range(0, top_row)), 1'($urandom), 1'($urandom));
      end else begin
        tick(1'($urandom), triggers_free ? 1'($urandom) : 1'b0);
      end
    end
  endtask

  initial begin
    int lens [7];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.mode = MODE_TICK;
    req.start_trigger = 1'b0;
    req.stop_trigger = 1'b0;
    req.sample_0 = '0;
    req.sample_1 = '0;
    req.sample_2 = '0;
    req.sample_3 = '0;
    req.read_row = '0;
    res.ready = 1'b1;
    tick_count = 0;
    read_count = 0;
    write_count = 0;
    burst_left = 0;
    gappy = 1'b0;
    stall_style = 0;
    stall_left = 0;
    stall_mask = 8'hff;
    stall_beat = 0;
    ring_span = RLEN_RESET;
    quiet = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    read_at('0, 1'b0, 1'b0);
    send_word(MODE_TICK, 1'b0, 1'b1, '1, '1, '1, '1, '1);
    send_word(MODE_TICK, 1'b1, 1'b0, '0, '0, '0, '0, '0);
    send_word(MODE_TICK, 1'b1, 1'b0, '1, '1, '1, '1, '0);
    send_word(MODE_TICK, 1'b0, 1'b0, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
              32'h55555555, '0);
    read_at(10'd0, 1'b0, 1'b0);
    read_at(10'd1, 1'b1, 1'b1);
    read_at(10'd2, 1'b0, 1'b0);
    read_at(10'd3, 1'b0, 1'b0);
    read_at(10'd1023, 1'b0, 1'b0);
    reg_write(REG_RING_LEN, 32'd1);
    repeat (3) tick(1'b0, 1'b0);
    read_at(10'd0, 1'b0, 1'b0);
    read_at(10'd1, 1'b0, 1'b0);
    reg_write(REG_RING_LEN, 32'd0);
    tick(1'b1, 1'b0);
    read_at(10'd0, 1'b0, 1'b0);
    reg_write(REG_RING_LEN, 32'd3);
    repeat (4) tick(1'b0, 1'b0);
    read_at(10'd0, 1'b0, 1'b0);
    read_at(10'd1, 1'b0, 1'b0);
    read_at(10'd2, 1'b0, 1'b0);
    reg_write(REG_POST_STOP, 32'd65535);

    lens = '{$urandom_range(2, 9), 2, $urandom_range(10, 64), 1, 2047,
             $urandom_range(65, 300), 0};
    for (int p = 0; p < 7; p++) begin
      if (p == 2) reg_write(REG_POST_STOP, 32'($urandom_range(0, 65535)));
      if (p == 4) reg_write(REG_POST_STOP, 32'd0);
      reg_write(REG_RING_LEN, 32'(lens[p]));
      run_phase(60, 35, p % 4, 1'b0);
    end

    // A long run on the full-size ring stores several hundred rows for deep reads.
    reg_write(REG_RING_LEN, 32'd1024);
    run_phase(585, 10, 2, 1'b0);

    reg_write(REG_POST_STOP, $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 40)));
    reg_write(REG_RING_LEN, 32'($urandom_range(20, 200)));
    run_phase(20, 20, 3, 1'b0);
    tick(1'($urandom), 1'b1);
    run_phase(100, 30, 1, 1'b1);

    req.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Sent %0d ticks and %0d reads with %0d register writes.",
             tick_count, read_count, write_count);
    $display("%0d reads hit a stored row; the ring held up to %0d rows.",
             valid_reads, peak_rows);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
